[src/bsc_pkg.sv]
package bsc_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned CNT_W = $clog2(XLEN);

    // register indexes on the configuration channel
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2 = 3'd3;
    localparam logic [2:0] REG_MC_MD = 3'd4;
    localparam logic [2:0] REG_OSS = 3'd5;

    localparam logic ACT_TEMP = 1'b0;
    localparam logic ACT_PRES = 1'b1;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_P_SQ_GAIN = 32'd3038;
    localparam logic [31:0] C_P_LIN_GAIN = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_OFFSET = 32'd3791;
    localparam logic [31:0] C_P_SCALE = 32'd50000;
    localparam logic [31:0] C_SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] C_X3_BIAS = 32'd32768;
    localparam logic [1:0] C_OSS_RESET = 2'd3;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

[src/bsc_alu.sv]
module bsc_alu
    import bsc_pkg::*;
#(
    parameter int unsigned W = XLEN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_req     i_req,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int unsigned CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    t_alu_op       r_op;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;    // product, or partial remainder
    logic [W-1:0]  r_x;      // multiplicand, or dividend/quotient
    logic [W-1:0]  r_y;      // multiplier, or divisor

    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    assign w_shift = {r_acc, r_x[W-1]};
    assign w_diff  = w_shift - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_x    <= i_a;
                r_y    <= i_b;
            end else if (r_busy) begin
                case (r_op)
                    ALU_MUL: begin
                        // one multiplier bit a cycle, low word kept
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[W-1:1]};
                    end
                    ALU_DIV: begin
                        // restoring step, one quotient bit a cycle
                        if (!w_diff[W]) begin
                            r_acc <= w_diff[W-1:0];
                            r_x   <= {r_x[W-2:0], 1'b1};
                        end else begin
                            r_acc <= w_shift[W-1:0];
                            r_x   <= {r_x[W-2:0], 1'b0};
                        end
                    end
                    default: ;
                endcase
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == ALU_MUL) ? r_acc : r_x;

endmodule

[src/barometric_sensor_compensation_core.sv]
// Barometric sensor compensation core.
// Input channel (i_valid/o_ready) takes one word: i_action selects a
// temperature (0) or pressure (1) conversion of i_raw_reading. Output
// channel (o_valid/i_ready) returns one word per input: o_value and
// o_divide_error (set, with o_value zero, when a divisor was zero).
// Calibration words and oversampling are written over the configuration
// channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data); the user must
// write them only while idle, as the block itself does not enforce it. All
// multiplies and divides run on one shared bit-serial unit. Temperature: 2
// operations. Pressure: 10 multiplies and 1 divide. A zero divisor ends a
// word before its divide. One word is in work at a time; the next is taken
// the cycle after the result registers. o_ready is high while the sequencer
// is idle, even when a result still waits. When the receiver stalls, a
// finished result holds in a staging register until the output register
// frees. Reset clears the calibration words, sets oversampling to 3 and
// clears the kept temperature term.
module barometric_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  logic [18:0]     i_raw_reading,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [XLEN-1:0] o_value,
    output logic            o_divide_error,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [XLEN-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_T1, S_T2,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
        S_HOLD
    } t_state;

    t_state        r_state;
    logic [31:0]   r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0]    r_oss;
    logic [31:0]   r_b5;
    logic [18:0]   r_raw;
    logic [31:0]   r_b6, r_sq, r_t0, r_b3, r_b4, r_p;
    logic          r_neg, r_shq;
    t_alu_req      r_req;
    logic [31:0]   r_alu_a, r_alu_b;
    logic [31:0]   r_fin_value;
    logic          r_fin_err;
    logic          r_out_valid;
    logic [31:0]   r_value;
    logic          r_err;

    logic          w_done;
    logic [31:0]   w_res;

    bsc_alu #(.W(XLEN)) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_req),
        .i_a      (r_alu_a),
        .i_b      (r_alu_b),
        .o_done   (w_done),
        .o_result (w_res)
    );

    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    logic [31:0] w_b1, w_b2, w_mc, w_md;
    logic [31:0] w_x1t, w_den, w_mcs, w_num_mag, w_den_mag, w_q, w_b5n, w_tout;
    logic [31:0] w_sq, w_r11, w_r13, w_r16, w_x3p, w_b3, w_x3b, w_b4;
    logic [31:0] w_b6, w_sub, w_scale, w_pv, w_p8, w_pfin;

    always_comb begin
        w_ac1 = {{16{r_ac12[31]}}, r_ac12[31:16]};
        w_ac2 = {{16{r_ac12[15]}}, r_ac12[15:0]};
        w_ac3 = {{16{r_ac34[31]}}, r_ac34[31:16]};
        w_ac4 = {16'b0, r_ac34[15:0]};
        w_ac5 = {16'b0, r_ac56[31:16]};
        w_ac6 = {16'b0, r_ac56[15:0]};
        w_b1  = {{16{r_b12[31]}}, r_b12[31:16]};
        w_b2  = {{16{r_b12[15]}}, r_b12[15:0]};
        w_mc  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
        w_md  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};

        // temperature
        w_x1t     = 32'($signed(w_res) >>> 15);
        w_den     = w_x1t + w_md;
        w_mcs     = {w_mc[20:0], 11'b0};
        w_num_mag = w_mcs[31] ? (32'd0 - w_mcs) : w_mcs;
        w_den_mag = w_den[31] ? (32'd0 - w_den) : w_den;
        w_q       = r_neg ? (32'd0 - w_res) : w_res;
        w_b5n     = r_t0 + w_q;
        w_tout    = 32'($signed(w_b5n + 32'd8) >>> 4);

        // pressure
        w_b6    = r_b5 - C_B6_OFFSET;
        w_sq    = 32'($signed(w_res) >>> 12);
        w_r11   = 32'($signed(w_res) >>> 11);
        w_r13   = 32'($signed(w_res) >>> 13);
        w_r16   = 32'($signed(w_res) >>> 16);
        w_x3p   = r_t0 + w_r11;
        w_b3    = 32'($signed((({w_ac1[29:0], 2'b0} + w_x3p) << r_oss) + 32'd2) >>> 2);
        w_x3b   = 32'($signed(r_t0 + w_r16 + 32'd2) >>> 2);
        w_b4    = w_res >> 15;
        w_sub   = {13'b0, r_raw} - r_b3;
        w_scale = C_P_SCALE >> r_oss;
        w_pv    = r_shq ? {w_res[30:0], 1'b0} : w_res;
        w_p8    = 32'($signed(w_pv) >>> 8);
        w_pfin  = r_p + 32'($signed(r_t0 + w_r16 + C_P_OFFSET) >>> 4);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ac12      <= '0;
            r_ac34      <= '0;
            r_ac56      <= '0;
            r_b12       <= '0;
            r_mcmd      <= '0;
            r_oss       <= C_OSS_RESET;
            r_b5        <= '0;
            r_req       <= '{start: 1'b0, op: ALU_MUL};
            r_out_valid <= 1'b0;
        end else begin
            // a start pulse lasts one cycle; no new request is issued then
            if (r_req.start) begin
                r_req.start <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_AC1_AC2: r_ac12 <= i_cfg_data[31:0];
                    REG_AC3_AC4: r_ac34 <= i_cfg_data[31:0];
                    REG_AC5_AC6: r_ac56 <= i_cfg_data[31:0];
                    REG_B1_B2:   r_b12  <= i_cfg_data[31:0];
                    REG_MC_MD:   r_mcmd <= i_cfg_data[31:0];
                    REG_OSS:     r_oss  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // drop the word once taken, unless the staged one moves in now
            if (r_out_valid && i_ready && r_state != S_HOLD) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_raw     <= i_raw_reading;
                        r_req     <= '{start: 1'b1, op: ALU_MUL};
                        if (i_action == ACT_TEMP) begin
                            r_alu_a <= {16'b0, i_raw_reading[15:0]} - w_ac6;
                            r_alu_b <= w_ac5;
                            r_state <= S_T1;
                        end else begin
                            r_b6    <= w_b6;
                            r_alu_a <= w_b6;
                            r_alu_b <= w_b6;
                            r_state <= S_P1;
                        end
                    end
                end
                S_T1: begin
                    if (w_done) begin
                        if (w_den == '0) begin
                            r_fin_value <= '0;
                            r_fin_err   <= 1'b1;
                            r_state     <= S_HOLD;
                        end else begin
                            r_t0    <= w_x1t;
                            r_neg   <= w_mcs[31] ^ w_den[31];
                            r_alu_a <= w_num_mag;
                            r_alu_b <= w_den_mag;
                            r_req   <= '{start: 1'b1, op: ALU_DIV};
                            r_state <= S_T2;
                        end
                    end
                end
                S_T2: begin
                    if (w_done) begin
                        r_b5        <= w_b5n;
                        r_fin_value <= w_tout;
                        r_fin_err   <= 1'b0;
                        r_state     <= S_HOLD;
                    end
                end
                S_P1: begin
                    if (w_done) begin
                        r_sq    <= w_sq;
                        r_alu_a <= w_b2;
                        r_alu_b <= w_sq;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    if (w_done) begin
                        r_t0    <= w_r11;
                        r_alu_a <= w_ac2;
                        r_alu_b <= r_b6;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P3;
                    end
                end
                S_P3: begin
                    if (w_done) begin
                        r_b3    <= w_b3;
                        r_alu_a <= w_ac3;
                        r_alu_b <= r_b6;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P4;
                    end
                end
                S_P4: begin
                    if (w_done) begin
                        r_t0    <= w_r13;
                        r_alu_a <= w_b1;
                        r_alu_b <= r_sq;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P5;
                    end
                end
                S_P5: begin
                    if (w_done) begin
                        r_alu_a <= w_ac4;
                        r_alu_b <= w_x3b + C_X3_BIAS;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P6;
                    end
                end
                S_P6: begin
                    if (w_done) begin
                        if (w_b4 == '0) begin
                            r_fin_value <= '0;
                            r_fin_err   <= 1'b1;
                            r_state     <= S_HOLD;
                        end else begin
                            r_b4    <= w_b4;
                            r_alu_a <= w_sub;
                            r_alu_b <= w_scale;
                            r_req   <= '{start: 1'b1, op: ALU_MUL};
                            r_state <= S_P7;
                        end
                    end
                end
                S_P7: begin
                    if (w_done) begin
                        // below the sign bit: double first, else double the quotient
                        if ((w_res & C_SIGN_BIT) == '0) begin
                            r_alu_a <= {w_res[30:0], 1'b0};
                            r_shq   <= 1'b0;
                        end else begin
                            r_alu_a <= w_res;
                            r_shq   <= 1'b1;
                        end
                        r_alu_b <= r_b4;
                        r_req   <= '{start: 1'b1, op: ALU_DIV};
                        r_state <= S_P8;
                    end
                end
                S_P8: begin
                    if (w_done) begin
                        r_p     <= w_pv;
                        r_alu_a <= w_p8;
                        r_alu_b <= w_p8;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P9;
                    end
                end
                S_P9: begin
                    if (w_done) begin
                        r_alu_a <= w_res;
                        r_alu_b <= C_P_SQ_GAIN;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P10;
                    end
                end
                S_P10: begin
                    if (w_done) begin
                        r_t0    <= w_r16;
                        r_alu_a <= C_P_LIN_GAIN;
                        r_alu_b <= r_p;
                        r_req   <= '{start: 1'b1, op: ALU_MUL};
                        r_state <= S_P11;
                    end
                end
                S_P11: begin
                    if (w_done) begin
                        r_fin_value <= w_pfin;
                        r_fin_err   <= 1'b0;
                        r_state     <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // move the word out once the output register frees
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_value     <= r_fin_value;
                        r_err       <= r_fin_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_value        = r_value;
    assign o_divide_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_value == '0)
        else $error("divide error with nonzero value");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state != S_IDLE && r_state != S_HOLD)
        else $error("arithmetic unit finished with no conversion running");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_req.start && r_req.op == ALU_MUL)
        else $error("accepted word did not start a multiply");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD && !(r_out_valid && !i_ready) |=> o_valid)
        else $error("finished result not moved to output");

endmodule
